### src/ftp_pkg.sv
// ----------------------------------------------------------------------------
// ftp_pkg
// shared types and constants of the fuzzy temperature to pwm controller
// ----------------------------------------------------------------------------
package ftp_pkg;

    localparam int TEMP_W        = 12;
    localparam int CFG_IDX_W     = 3;
    localparam int MU_W          = 13;   // holds the largest membership scale, 4096
    localparam int NUM_SETS      = 5;
    localparam int QUEUE_DEPTH   = 4;    // power of two
    localparam int DEF_DUTY_BITS = 10;
    localparam int DEF_MU_SCALE  = 48;

    // register reset values
    localparam logic signed [TEMP_W-1:0] RST_LOW_LIMIT  = 12'sd768;
    localparam logic signed [TEMP_W-1:0] RST_HIGH_LIMIT = 12'sd816;
    localparam int RST_LEVEL_VERY_COLD = 1023;
    localparam int RST_LEVEL_COLD      = 500;
    localparam int RST_LEVEL_OK        = 250;
    localparam int RST_LEVEL_WARM      = 100;
    localparam int RST_LEVEL_VERY_WARM = 0;

    // membership breakpoints, 1/16 degree
    localparam logic signed [TEMP_W:0] BP_768 = 13'sd768;
    localparam logic signed [TEMP_W:0] BP_776 = 13'sd776;
    localparam logic signed [TEMP_W:0] BP_780 = 13'sd780;
    localparam logic signed [TEMP_W:0] BP_784 = 13'sd784;
    localparam logic signed [TEMP_W:0] BP_792 = 13'sd792;
    localparam logic signed [TEMP_W:0] BP_800 = 13'sd800;
    localparam logic signed [TEMP_W:0] BP_808 = 13'sd808;
    localparam logic signed [TEMP_W:0] BP_816 = 13'sd816;
    localparam logic signed [TEMP_W:0] BP_820 = 13'sd820;
    localparam logic signed [TEMP_W:0] BP_824 = 13'sd824;
    localparam logic signed [TEMP_W:0] BP_832 = 13'sd832;

    typedef enum logic [1:0] {
        ZONE_COLD  = 2'd0,
        ZONE_FUZZY = 2'd1,
        ZONE_HOT   = 2'd2
    } t_zone;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOW_LIMIT       = 3'd0,
        CFG_HIGH_LIMIT      = 3'd1,
        CFG_LEVEL_VERY_COLD = 3'd2,
        CFG_LEVEL_COLD      = 3'd3,
        CFG_LEVEL_OK        = 3'd4,
        CFG_LEVEL_WARM      = 3'd5,
        CFG_LEVEL_VERY_WARM = 3'd6
    } t_cfg_index;

    // classified word between front and back
    typedef struct packed {
        t_zone                          zone;
        logic [NUM_SETS-1:0][MU_W-1:0]  mu;
    } t_fuzz;

    // side info that rides along the divider
    typedef struct packed {
        t_zone zone;
        logic  den_zero;
    } t_tag;

endpackage

### src/ftp_front.sv
// ----------------------------------------------------------------------------
// ftp_front
// zone classification and membership evaluation, one registered stage
// ----------------------------------------------------------------------------
module ftp_front #(
    parameter int MU_SCALE = ftp_pkg::DEF_MU_SCALE
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ftp_pkg::TEMP_W-1:0]   i_temperature,
    input  logic signed [ftp_pkg::TEMP_W-1:0]   i_low_limit,
    input  logic signed [ftp_pkg::TEMP_W-1:0]   i_high_limit,
    input  logic                                i_q_full,
    output logic                                o_item_valid,
    output ftp_pkg::t_fuzz                      o_item
);

    localparam int MU_W = ftp_pkg::MU_W;

    logic                               r_valid;
    ftp_pkg::t_fuzz                     r_item;
    ftp_pkg::t_fuzz                     n_item;
    logic signed [ftp_pkg::TEMP_W:0]    t;
    logic [MU_W-1:0]                    mu8_tab  [9];
    logic [MU_W-1:0]                    mu12_tab [13];
    logic [MU_W-1:0]                    mu16_tab [17];
    logic signed [ftp_pkg::TEMP_W:0]    d0, d1r, d1f, d2r, d2f, d3r, d3f, d4;

    // slope tables, dist * scale / width truncated
    for (genvar g = 0; g < 9; g++) begin : g_tab8
        localparam int V = g * MU_SCALE / 8;
        assign mu8_tab[g] = MU_W'(V);
    end
    for (genvar g = 0; g < 13; g++) begin : g_tab12
        localparam int V = g * MU_SCALE / 12;
        assign mu12_tab[g] = MU_W'(V);
    end
    for (genvar g = 0; g < 17; g++) begin : g_tab16
        localparam int V = g * MU_SCALE / 16;
        assign mu16_tab[g] = MU_W'(V);
    end

    assign t   = {i_temperature[ftp_pkg::TEMP_W-1], i_temperature};
    assign d0  = ftp_pkg::BP_776 - t;
    assign d1r = t - ftp_pkg::BP_768;
    assign d1f = ftp_pkg::BP_792 - t;
    assign d2r = t - ftp_pkg::BP_784;
    assign d2f = ftp_pkg::BP_816 - t;
    assign d3r = t - ftp_pkg::BP_808;
    assign d3f = ftp_pkg::BP_832 - t;
    assign d4  = t - ftp_pkg::BP_824;

    always_comb begin
        if (i_temperature < i_low_limit) begin
            n_item.zone = ftp_pkg::ZONE_COLD;
        end else if (i_temperature > i_high_limit) begin
            n_item.zone = ftp_pkg::ZONE_HOT;
        end else begin
            n_item.zone = ftp_pkg::ZONE_FUZZY;
        end

        // very cold, left shoulder
        if (t <= ftp_pkg::BP_768) begin
            n_item.mu[0] = MU_W'(MU_SCALE);
        end else if (t <= ftp_pkg::BP_776) begin
            n_item.mu[0] = mu8_tab[d0[3:0]];
        end else begin
            n_item.mu[0] = '0;
        end

        // cold
        if (t <= ftp_pkg::BP_768 || t >= ftp_pkg::BP_792) begin
            n_item.mu[1] = '0;
        end else if (t <= ftp_pkg::BP_780) begin
            n_item.mu[1] = mu12_tab[d1r[3:0]];
        end else begin
            n_item.mu[1] = mu12_tab[d1f[3:0]];
        end

        // ok
        if (t <= ftp_pkg::BP_784 || t >= ftp_pkg::BP_816) begin
            n_item.mu[2] = '0;
        end else if (t <= ftp_pkg::BP_800) begin
            n_item.mu[2] = mu16_tab[d2r[4:0]];
        end else begin
            n_item.mu[2] = mu16_tab[d2f[4:0]];
        end

        // warm
        if (t <= ftp_pkg::BP_808 || t >= ftp_pkg::BP_832) begin
            n_item.mu[3] = '0;
        end else if (t <= ftp_pkg::BP_820) begin
            n_item.mu[3] = mu12_tab[d3r[3:0]];
        end else begin
            n_item.mu[3] = mu12_tab[d3f[3:0]];
        end

        // very warm, right shoulder
        if (t >= ftp_pkg::BP_832) begin
            n_item.mu[4] = MU_W'(MU_SCALE);
        end else if (t >= ftp_pkg::BP_824) begin
            n_item.mu[4] = mu8_tab[d4[3:0]];
        end else begin
            n_item.mu[4] = '0;
        end
    end

    // holds only while a word waits on a full queue
    assign o_stall      = r_valid && i_q_full;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= n_item;
        end
    end

endmodule

### src/ftp_queue.sv
// ----------------------------------------------------------------------------
// ftp_queue
// short fifo of classified words between front and back
// ----------------------------------------------------------------------------
module ftp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ftp_pkg::t_fuzz  i_data,
    input  logic            i_pop,
    output ftp_pkg::t_fuzz  o_data,
    output logic            o_full,
    output logic            o_empty
);

    localparam int DEPTH = ftp_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    ftp_pkg::t_fuzz r_mem [DEPTH];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");

endmodule

### src/ftp_back.sv
// ----------------------------------------------------------------------------
// ftp_back
// weighted sums, pipelined centroid divide with rounding, output register
// ----------------------------------------------------------------------------
module ftp_back #(
    parameter int DUTY_BITS = ftp_pkg::DEF_DUTY_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_q_empty,
    input  ftp_pkg::t_fuzz                              i_q_data,
    output logic                                        o_q_pop,
    input  logic [ftp_pkg::NUM_SETS-1:0][DUTY_BITS-1:0] i_levels,
    output logic                                        o_valid,
    input  logic                                        i_stall,
    output logic [DUTY_BITS-1:0]                        o_pwm_duty,
    output ftp_pkg::t_zone                              o_zone
);

    localparam int MU_W = ftp_pkg::MU_W;
    localparam int NS   = ftp_pkg::NUM_SETS;
    localparam int PW   = MU_W + DUTY_BITS;
    localparam int NUMW = PW + 3;
    localparam int DENW = MU_W + 3;
    localparam int NW   = NUMW + 2;
    localparam int DW   = DENW + 1;
    localparam int QB   = DUTY_BITS + 1;

    logic                       en;

    // product stage
    logic                       r_v0;
    ftp_pkg::t_zone             r_zone0;
    logic [NS-1:0][PW-1:0]      r_prod;
    logic [NS-1:0][MU_W-1:0]    r_mu;

    // sum stage
    logic [NUMW-1:0]            num;
    logic [DENW-1:0]            den;

    // divider stages, index 0 is the sum stage
    logic                       r_vld [QB+1];
    ftp_pkg::t_tag              r_tag [QB+1];
    logic [NW-1:0]              r_rem [QB+1];
    logic [DW-1:0]              r_div [QB+1];
    logic [QB-1:0]              r_quo [QB+1];

    logic                       r_ovalid;
    logic [DUTY_BITS-1:0]       r_duty;
    ftp_pkg::t_zone             r_zone;
    logic [DUTY_BITS-1:0]       n_duty;

    assign en      = !r_ovalid || !i_stall;
    assign o_q_pop = en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zone0 <= i_q_data.zone;
            r_mu    <= i_q_data.mu;
            for (int j = 0; j < NS; j++) begin
                r_prod[j] <= PW'(i_q_data.mu[j]) * PW'(i_levels[j]);
            end
        end
    end

    always_comb begin
        num = '0;
        den = '0;
        for (int j = 0; j < NS; j++) begin
            num = num + NUMW'(r_prod[j]);
            den = den + DENW'(r_mu[j]);
        end
    end

    // round half up: (2 num + den) / (2 den)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0].zone     <= r_zone0;
            r_tag[0].den_zero <= (den == '0);
            r_rem[0]          <= {num, 1'b0} + NW'(den);
            r_div[0]          <= {den, 1'b0};
            r_quo[0]          <= '0;
        end
    end

    // restoring divide, one quotient bit per stage, msb first
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int SH = QB - 1 - k;
        logic [NW-1:0] shd;
        logic          ge;

        assign shd = NW'(r_div[k]) << SH;
        assign ge  = (r_rem[k] >= shd);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_tag[k+1]     <= r_tag[k];
                r_div[k+1]     <= r_div[k];
                r_rem[k+1]     <= ge ? (r_rem[k] - shd) : r_rem[k];
                r_quo[k+1]     <= r_quo[k] | (QB'(ge) << SH);
            end
        end
    end

    always_comb begin
        case (r_tag[QB].zone)
            ftp_pkg::ZONE_COLD: n_duty = i_levels[0];
            ftp_pkg::ZONE_FUZZY: begin
                if (r_tag[QB].den_zero) begin
                    n_duty = '0;
                end else if (r_quo[QB][QB-1]) begin
                    n_duty = '1;
                end else begin
                    n_duty = r_quo[QB][DUTY_BITS-1:0];
                end
            end
            default: n_duty = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (en) begin
            r_ovalid <= r_vld[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_duty <= n_duty;
            r_zone <= r_tag[QB].zone;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_pwm_duty = r_duty;
    assign o_zone     = r_zone;

    a_hot_is_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_zone == ftp_pkg::ZONE_HOT |-> r_duty == '0)
        else $error("hot zone word with nonzero duty");

    a_zone_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_zone == ftp_pkg::ZONE_COLD || r_zone == ftp_pkg::ZONE_FUZZY
                     || r_zone == ftp_pkg::ZONE_HOT)
        else $error("output word with unused zone code");

endmodule

### src/fuzzy_temperature_to_pwm.sv
// ----------------------------------------------------------------------------
// fuzzy_temperature_to_pwm
// fuzzy heater duty controller with centroid defuzzification
// ----------------------------------------------------------------------------
// takes one signed temperature word in 1/16 degree units and returns one word
// holding a heater duty and a zone code; below the low limit the duty is the
// very cold level (zone 0), above the high limit it is 0 (zone 2), otherwise
// five fixed membership sets are weighted by the level registers and the
// centroid is rounded half up and clamped (zone 1); throughput is one word per
// clock while no stall holds the flow, set by the one-bit-per-stage divider
// pipeline; a word passes the front stage, queue, product stage, sum stage,
// DUTY_BITS + 1 divider stages and output register; a four-word queue between
// classification and arithmetic lets the two halves stall on their own, and a
// finished word waiting in the output register holds the whole back pipeline;
// the user must write registers through a plain write port while the block is
// idle, which the block itself does not enforce; writes to the unused index are dropped
// ----------------------------------------------------------------------------
module fuzzy_temperature_to_pwm #(
    parameter int DUTY_BITS = ftp_pkg::DEF_DUTY_BITS,   // 8 .. 16
    parameter int MU_SCALE  = ftp_pkg::DEF_MU_SCALE,    // 48 .. 4096
    localparam int CFG_W    = (DUTY_BITS > ftp_pkg::TEMP_W) ? DUTY_BITS : ftp_pkg::TEMP_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // register write port
    input  logic                                i_cfg_we,
    input  logic [ftp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_W-1:0]                    i_cfg_data,

    // temperature words in
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ftp_pkg::TEMP_W-1:0]   i_temperature,

    // duty words out
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [DUTY_BITS-1:0]                o_pwm_duty,
    output logic [1:0]                          o_zone
);

    localparam int NS = ftp_pkg::NUM_SETS;

    // configuration registers
    logic signed [ftp_pkg::TEMP_W-1:0]  r_low_limit;
    logic signed [ftp_pkg::TEMP_W-1:0]  r_high_limit;
    logic [NS-1:0][DUTY_BITS-1:0]       r_levels;

    // front to queue to back
    logic               front_valid;
    ftp_pkg::t_fuzz     front_item;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    ftp_pkg::t_fuzz     q_head;
    ftp_pkg::t_zone     back_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_limit  <= ftp_pkg::RST_LOW_LIMIT;
            r_high_limit <= ftp_pkg::RST_HIGH_LIMIT;
            r_levels[0]  <= DUTY_BITS'(ftp_pkg::RST_LEVEL_VERY_COLD);
            r_levels[1]  <= DUTY_BITS'(ftp_pkg::RST_LEVEL_COLD);
            r_levels[2]  <= DUTY_BITS'(ftp_pkg::RST_LEVEL_OK);
            r_levels[3]  <= DUTY_BITS'(ftp_pkg::RST_LEVEL_WARM);
            r_levels[4]  <= DUTY_BITS'(ftp_pkg::RST_LEVEL_VERY_WARM);
        end else if (i_cfg_we) begin
            case (ftp_pkg::t_cfg_index'(i_cfg_index))
                ftp_pkg::CFG_LOW_LIMIT:       r_low_limit  <= i_cfg_data[ftp_pkg::TEMP_W-1:0];
                ftp_pkg::CFG_HIGH_LIMIT:      r_high_limit <= i_cfg_data[ftp_pkg::TEMP_W-1:0];
                ftp_pkg::CFG_LEVEL_VERY_COLD: r_levels[0]  <= i_cfg_data[DUTY_BITS-1:0];
                ftp_pkg::CFG_LEVEL_COLD:      r_levels[1]  <= i_cfg_data[DUTY_BITS-1:0];
                ftp_pkg::CFG_LEVEL_OK:        r_levels[2]  <= i_cfg_data[DUTY_BITS-1:0];
                ftp_pkg::CFG_LEVEL_WARM:      r_levels[3]  <= i_cfg_data[DUTY_BITS-1:0];
                ftp_pkg::CFG_LEVEL_VERY_WARM: r_levels[4]  <= i_cfg_data[DUTY_BITS-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // zone decision and memberships
    ftp_front #(
        .MU_SCALE      (MU_SCALE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_temperature (i_temperature),
        .i_low_limit   (r_low_limit),
        .i_high_limit  (r_high_limit),
        .i_q_full      (q_full),
        .o_item_valid  (front_valid),
        .o_item        (front_item)
    );

    // decoupling queue, push whenever the front holds a word and there is room
    ftp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid && !q_full),
        .i_data  (front_item),
        .i_pop   (q_pop),
        .o_data  (q_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // centroid arithmetic and output register
    ftp_back #(
        .DUTY_BITS  (DUTY_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_q_data   (q_head),
        .o_q_pop    (q_pop),
        .i_levels   (r_levels),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pwm_duty (o_pwm_duty),
        .o_zone     (back_zone)
    );

    assign o_zone = back_zone;

endmodule
